FILE: hw/rtl/mbrtu_pkg.sv
package mbrtu_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0]  SLAVE_ID_RESET     = 8'd1;
   localparam logic [9:0]  FRAME_GAP_RESET    = 10'd2;
   localparam logic [15:0] LINK_TIMEOUT_RESET = 16'd1000;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [1:0] {
      CSR_SLAVE_ID     = 2'd0,
      CSR_FRAME_GAP    = 2'd1,
      CSR_LINK_TIMEOUT = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      REQ_BYTE    = 2'd0,
      REQ_TICK    = 2'd1,
      REQ_HOST_WR = 2'd2,
      REQ_HOST_RD = 2'd3
   } req_kind_type;

   localparam logic [7:0] FN_READ_HI     = 8'd1;
   localparam logic [7:0] FN_READ_LO     = 8'd2;
   localparam logic [7:0] FN_READ_HOLD   = 8'd3;
   localparam logic [7:0] FN_READ_INPUT  = 8'd4;
   localparam logic [7:0] FN_WRITE_COIL  = 8'd5;
   localparam logic [7:0] FN_WRITE_REG   = 8'd6;
   localparam logic [7:0] FN_WRITE_MULTI = 8'd16;

   typedef struct packed {
      logic [7:0]  slave_id;
      logic [9:0]  frame_gap;
      logic [15:0] link_timeout;
   } cfg_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/mbrtu_csr.sv
module mbrtu_csr
   import mbrtu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   csr_index_type idx;
   logic          wr_en;

   assign idx        = csr_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_id     <= SLAVE_ID_RESET;
         cfg_ff.frame_gap    <= FRAME_GAP_RESET;
         cfg_ff.link_timeout <= LINK_TIMEOUT_RESET;
      end else if (wr_en) begin
         unique case (idx)
            CSR_SLAVE_ID:     cfg_ff.slave_id     <= csr_pwdata[7:0];
            CSR_FRAME_GAP:    cfg_ff.frame_gap    <= csr_pwdata[9:0];
            CSR_LINK_TIMEOUT: cfg_ff.link_timeout <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_SLAVE_ID:     csr_prdata = CSR_DATA_W'(cfg_ff.slave_id);
         CSR_FRAME_GAP:    csr_prdata = CSR_DATA_W'(cfg_ff.frame_gap);
         CSR_LINK_TIMEOUT: csr_prdata = CSR_DATA_W'(cfg_ff.link_timeout);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

FILE: hw/rtl/modbus_rtu_slave_register_server_core.sv
// Modbus RTU slave core with a local table of 16-bit registers.
// req channel: one transaction per received serial byte, millisecond tick,
// host register write or host register read (kind in req_tuser).
// rsp channel: one transaction per reply byte when a frame is answered,
// else exactly one transaction carrying the read, write-event and link
// status; rsp_tlast marks the final reply byte.
// A transaction that closes no frame gives its result from ST_RESULT (a
// host read passes ST_HREAD first). A closed frame is checked at one byte
// per cycle, then the reply goes out at one byte per cycle while rsp is
// not stalled; each register a read reply returns passes ST_FETCH and
// ST_LATCH for the table's read port. req_tready is high only while
// the core is between transactions; a stalled rsp channel holds the core
// in its current reply byte, while the output register lets the next
// request in once the last result of the previous one is loaded.
// Reset clears the frame state, marks every table entry as zero through
// per-entry valid bits, restores the configuration defaults and reports
// the link down.
module modbus_rtu_slave_register_server_core
   import mbrtu_pkg::*;
#(
   parameter int NUM_REGS      = 64,
   parameter int RX_BUF_BYTES  = 16,
   parameter int MAX_READ_REGS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rx_byte[7:0], host_reg[13:8], host_value[29:14], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tx_valid[0], tx_byte[8:1], read_valid[9], read_value[25:10],
   // write_event[26], written_reg[32:27], link_up[33], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int BW = $clog2(RX_BUF_BYTES);
   localparam int CW = $clog2(RX_BUF_BYTES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_HREAD, ST_RESULT, ST_CLOSE, ST_CRC, ST_DECODE,
      ST_WRITE2, ST_FETCH, ST_LATCH, ST_SEND, ST_CRC_LO, ST_CRC_HI
   } state_type;

   cfg_type cfg;

   mbrtu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   state_type      state_ff;
   logic [7:0]     buf_ff [RX_BUF_BYTES];
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  len_ff;
   logic [CW-1:0]  ptr_ff;
   logic           in_frame_ff;
   logic [9:0]     gap_ff;
   logic [15:0]    link_ff;
   logic [15:0]    crc_ff;
   logic           crc_ok_ff;
   logic [7:0]     code_ff;
   logic [AW-1:0]  addr_ff;
   logic [6:0]     qty_ff;
   logic           echo_ff;
   logic [7:0]     body_len_ff;
   logic [7:0]     k_ff;
   logic           have_word_ff;
   logic [15:0]    word_ff;
   logic           rd_valid_ff;
   logic [15:0]    rd_value_ff;
   logic           hin_ff;
   logic           ev_ff;
   logic [5:0]     ev_reg_ff;
   logic           rsp_valid_ff;
   logic [33:0]    rsp_data_ff;
   logic           rsp_last_ff;

   logic [15:0]    mem [NUM_REGS];
   logic [NUM_REGS-1:0] vld_ff;
   logic [15:0]    rdata_ff;
   logic           rvalid_ff;

   req_kind_type   req_kind;
   logic [7:0]     rx_byte;
   logic [5:0]     host_reg;
   logic [15:0]    host_value;
   logic           accept;
   logic           out_free;
   logic           link_up;
   logic           host_in;
   logic [AW-1:0]  host_idx;
   logic [BW-1:0]  buf_idx;
   logic [7:0]     buf_rd;
   logic [15:0]    addr16;
   logic [15:0]    qty16;
   logic           addr_ok;
   logic           dec_ok;
   logic [7:0]     kk;
   logic [AW-1:0]  word_addr;
   logic           fetch_mode;
   logic           need_fetch;
   logic [7:0]     send_byte;
   logic           mem_we;
   logic [AW-1:0]  mem_wa;
   logic [15:0]    mem_wd;
   logic [AW-1:0]  mem_ra;
   logic [9:0]     gap_inc;

   assign req_kind   = req_kind_type'(req_tuser);
   assign rx_byte    = req_tdata[7:0];
   assign host_reg   = req_tdata[13:8];
   assign host_value = req_tdata[29:14];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign link_up    = link_ff < cfg.link_timeout;
   assign host_in    = 17'(host_reg) < 17'(NUM_REGS);
   assign host_idx   = AW'(host_reg);
   assign gap_inc    = (gap_ff == 10'd1023) ? gap_ff : gap_ff + 10'd1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

   assign buf_idx = (state_ff == ST_SEND) ? k_ff[BW-1:0] : ptr_ff[BW-1:0];
   assign buf_rd  = buf_ff[buf_idx];

   assign addr16 = {buf_ff[2], buf_ff[3]};
   assign qty16  = {buf_ff[4], buf_ff[5]};
   assign addr_ok = 17'(addr16) < 17'(NUM_REGS);

   always_comb begin
      dec_ok = 1'b0;
      case (buf_ff[1]) inside
         FN_READ_HI, FN_READ_LO, FN_WRITE_COIL, FN_WRITE_REG: dec_ok = 1'b1;
         FN_READ_HOLD, FN_READ_INPUT:
            dec_ok = (qty16 != 16'd0) && (qty16 <= 16'(MAX_READ_REGS))
                     && (17'(addr16) + 17'(qty16) <= 17'(NUM_REGS));
         FN_WRITE_MULTI: dec_ok = 17'(addr16) + 17'd1 < 17'(NUM_REGS);
         default: dec_ok = 1'b0;
      endcase
      dec_ok = dec_ok & crc_ok_ff & addr_ok;
   end

   // reply byte generation
   assign kk         = k_ff - 8'd3;
   assign word_addr  = AW'(9'(addr_ff) + 9'(kk[7:1]));
   assign fetch_mode = ~echo_ff & (code_ff != FN_WRITE_MULTI);
   assign need_fetch = fetch_mode & (k_ff >= 8'd3) & ~kk[0] & ~have_word_ff;

   always_comb begin
      send_byte = 8'h00;
      if (echo_ff) begin
         send_byte = buf_rd;
      end else if (k_ff == 8'd0) begin
         send_byte = cfg.slave_id;
      end else if (k_ff == 8'd1) begin
         send_byte = code_ff;
      end else if (k_ff == 8'd2) begin
         case (code_ff) inside
            FN_READ_HI, FN_READ_LO:       send_byte = 8'd1;
            FN_READ_HOLD, FN_READ_INPUT:  send_byte = {qty_ff, 1'b0};
            default:                      send_byte = 8'd0;
         endcase
      end else begin
         case (code_ff) inside
            FN_READ_HI:                  send_byte = word_ff[15:8];
            FN_READ_LO:                  send_byte = word_ff[7:0];
            FN_READ_HOLD, FN_READ_INPUT: send_byte = kk[0] ? word_ff[7:0] : word_ff[15:8];
            default: begin
               if (k_ff == 8'd3)      send_byte = 8'(addr_ff);
               else if (k_ff == 8'd4) send_byte = 8'd0;
               else                   send_byte = 8'd2;
            end
         endcase
      end
   end

   // table port control
   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr16[AW-1:0];
      mem_wd = {buf_ff[4], buf_ff[5]};
      mem_ra = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            mem_ra = host_idx;
            mem_wa = host_idx;
            mem_wd = host_value;
            mem_we = accept & (req_kind == REQ_HOST_WR) & host_in;
         end
         ST_DECODE: begin
            mem_we = dec_ok & ((buf_ff[1] == FN_WRITE_COIL) | (buf_ff[1] == FN_WRITE_REG)
                               | (buf_ff[1] == FN_WRITE_MULTI));
            if (buf_ff[1] == FN_WRITE_MULTI) mem_wd = {buf_ff[9], buf_ff[10]};
         end
         ST_WRITE2: begin
            mem_we = 1'b1;
            mem_wa = addr_ff + AW'(1);
            mem_wd = {buf_ff[7], buf_ff[8]};
         end
         ST_FETCH: mem_ra = word_addr;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rdata_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (mem_we) vld_ff[mem_wa] <= 1'b1;
         rvalid_ff <= vld_ff[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         in_frame_ff  <= 1'b0;
         gap_ff       <= '0;
         link_ff      <= LINK_TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
         have_word_ff <= 1'b0;
      end else begin
         if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rd_valid_ff <= (req_kind == REQ_HOST_RD);
                  rd_value_ff <= '0;
                  hin_ff      <= host_in;
                  ev_ff       <= 1'b0;
                  ev_reg_ff   <= '0;
                  state_ff    <= ST_RESULT;
                  unique case (req_kind)
                     REQ_BYTE: begin
                        if (!in_frame_ff) begin
                           if (rx_byte == cfg.slave_id) begin
                              buf_ff[0]   <= rx_byte;
                              count_ff    <= CW'(1);
                              in_frame_ff <= 1'b1;
                              gap_ff      <= '0;
                           end
                        end else begin
                           buf_ff[count_ff[BW-1:0]] <= rx_byte;
                           gap_ff <= '0;
                           if (count_ff == CW'(RX_BUF_BYTES - 1)) begin
                              len_ff      <= CW'(RX_BUF_BYTES);
                              count_ff    <= '0;
                              in_frame_ff <= 1'b0;
                              state_ff    <= ST_CLOSE;
                           end else begin
                              count_ff <= count_ff + CW'(1);
                           end
                        end
                     end
                     REQ_TICK: begin
                        if (link_ff != 16'hFFFF) link_ff <= link_ff + 16'd1;
                        if (in_frame_ff) begin
                           if (gap_inc >= cfg.frame_gap) begin
                              len_ff      <= count_ff;
                              count_ff    <= '0;
                              in_frame_ff <= 1'b0;
                              gap_ff      <= '0;
                              state_ff    <= ST_CLOSE;
                           end else begin
                              gap_ff <= gap_inc;
                           end
                        end
                     end
                     REQ_HOST_RD: state_ff <= ST_HREAD;
                     default: ;
                  endcase
               end
            end
            ST_HREAD: begin
               rd_value_ff <= (hin_ff & rvalid_ff) ? rdata_ff : 16'd0;
               state_ff    <= ST_RESULT;
            end
            ST_RESULT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {link_up, ev_reg_ff, ev_ff, rd_value_ff, rd_valid_ff,
                                   8'h00, 1'b0};
                  rsp_last_ff  <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_CLOSE: begin
               ptr_ff    <= '0;
               crc_ff    <= CRC_INIT;
               crc_ok_ff <= 1'b1;
               if ((len_ff < CW'(8))
                   || !(((buf_ff[1] >= FN_READ_HI) && (buf_ff[1] <= FN_WRITE_REG))
                        || (buf_ff[1] == FN_WRITE_MULTI))
                   || ((buf_ff[1] == FN_WRITE_MULTI) && (len_ff < CW'(13))))
                  state_ff <= ST_RESULT;
               else
                  state_ff <= ST_CRC;
            end
            ST_CRC: begin
               ptr_ff <= ptr_ff + CW'(1);
               if (ptr_ff < len_ff - CW'(2)) begin
                  crc_ff <= crc_byte(crc_ff, buf_rd);
               end else if (ptr_ff == len_ff - CW'(2)) begin
                  crc_ok_ff <= crc_ok_ff & (buf_rd == crc_ff[7:0]);
               end else begin
                  crc_ok_ff <= crc_ok_ff & (buf_rd == crc_ff[15:8]);
                  state_ff  <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               code_ff      <= buf_ff[1];
               addr_ff      <= addr16[AW-1:0];
               qty_ff       <= qty16[6:0];
               k_ff         <= '0;
               crc_ff       <= CRC_INIT;
               have_word_ff <= 1'b0;
               echo_ff      <= 1'b0;
               if (!dec_ok) begin
                  state_ff <= ST_RESULT;
               end else begin
                  link_ff  <= '0;
                  state_ff <= ST_SEND;
                  unique case (buf_ff[1]) inside
                     FN_READ_HI, FN_READ_LO: body_len_ff <= 8'd4;
                     FN_READ_HOLD, FN_READ_INPUT:
                        body_len_ff <= 8'd3 + {qty16[6:0], 1'b0};
                     FN_WRITE_COIL, FN_WRITE_REG: begin
                        body_len_ff <= 8'd8;
                        echo_ff     <= 1'b1;
                        ev_ff       <= 1'b1;
                        ev_reg_ff   <= addr16[5:0];
                     end
                     default: begin
                        body_len_ff <= 8'd6;
                        ev_ff       <= 1'b1;
                        ev_reg_ff   <= addr16[5:0];
                        state_ff    <= ST_WRITE2;
                     end
                  endcase
               end
            end
            ST_WRITE2: state_ff <= ST_SEND;
            ST_FETCH:  state_ff <= ST_LATCH;
            ST_LATCH: begin
               word_ff      <= rvalid_ff ? rdata_ff : 16'd0;
               have_word_ff <= 1'b1;
               state_ff     <= ST_SEND;
            end
            ST_SEND: begin
               if (need_fetch) begin
                  state_ff <= ST_FETCH;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {link_up, ev_reg_ff, ev_ff, rd_value_ff, rd_valid_ff,
                                   send_byte, 1'b1};
                  rsp_last_ff  <= echo_ff & (k_ff == body_len_ff - 8'd1);
                  crc_ff       <= crc_byte(crc_ff, send_byte);
                  k_ff         <= k_ff + 8'd1;
                  if ((k_ff >= 8'd3) && kk[0]) have_word_ff <= 1'b0;
                  if (k_ff == body_len_ff - 8'd1) begin
                     have_word_ff <= 1'b0;
                     state_ff     <= echo_ff ? ST_IDLE : ST_CRC_LO;
                  end
               end
            end
            ST_CRC_LO: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {link_up, ev_reg_ff, ev_ff, rd_value_ff, rd_valid_ff,
                                   crc_ff[7:0], 1'b1};
                  rsp_last_ff  <= 1'b0;
                  state_ff     <= ST_CRC_HI;
               end
            end
            ST_CRC_HI: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {link_up, ev_reg_ff, ev_ff, rd_value_ff, rd_valid_ff,
                                   crc_ff[15:8], 1'b1};
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: hw/rtl/mbrtu_checker.sv
module mbrtu_checker
   import mbrtu_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // frame end only on a reply byte
   a_last_is_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[0])
      else $error("tlast without reply byte");

   // after reset the core is idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("core not idle after reset");

endmodule

bind modbus_rtu_slave_register_server_core mbrtu_checker u_checker (.*);

FILE: sim/tb_modbus_rtu_slave_register_server_core.sv
module tb_modbus_rtu_slave_register_server_core;
   import mbrtu_pkg::*;

   localparam int NREGS     = 64;
   localparam int BUF_BYTES = 16;
   localparam int MAX_RD    = 8;
   localparam int LIMIT     = 400000;

   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   rx_byte;
      logic [5:0]   host_reg;
      logic [15:0]  host_value;
   } req_item_t;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic        read_valid;
      logic [15:0] read_value;
      logic        write_event;
      logic [5:0]  written_reg;
      logic        link_up;
   } slave_out_t;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready, rsp_tlast;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   modbus_rtu_slave_register_server_core DUT (.*);

   // predictor state
   logic [15:0] table_m [NREGS];
   logic [7:0]  rxbuf_m [BUF_BYTES];
   int unsigned rxcnt_m, gap_m, link_m;
   bit          inframe_m;
   logic [7:0]  id_m;
   logic [9:0]  gapcfg_m;
   logic [15:0] tmo_m;

   req_item_t   pending_q [$];
   slave_out_t  reply_q [$];
   int errors, cycles;
   bit hold_rsp;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycles <= cycles + 1;

   initial begin
      cycles = 0;
      wait (cycles >= LIMIT);
      $display("FAILURE");
      $finish;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   function automatic logic [15:0] crc_of(input logic [7:0] b [], input int n);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int i = 0; i < n; i++) begin
         c ^= {8'h00, b[i]};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   // answer a closed frame, return reply bytes
   function automatic void answer_frame(ref logic [7:0] tx [$], ref bit wev,
                                         ref logic [5:0] wreg);
      logic [7:0] b [];
      int n, addr, qty, code;
      logic [15:0] c;
      n = rxcnt_m;
      b = new[BUF_BYTES];
      for (int i = 0; i < BUF_BYTES; i++) b[i] = rxbuf_m[i];
      if (n < 8) return;
      code = b[1];
      if (!((code >= FN_READ_HI && code <= FN_WRITE_REG) || code == FN_WRITE_MULTI)) return;
      if (code == FN_WRITE_MULTI && n < 13) return;
      c = crc_of(b, n - 2);
      if (b[n-2] != c[7:0] || b[n-1] != c[15:8]) return;
      addr = {b[2], b[3]};
      if (addr >= NREGS) return;
      case (code)
         FN_READ_HI, FN_READ_LO: begin
            tx = {id_m, code[7:0], 8'd1,
                  code == FN_READ_HI ? table_m[addr][15:8] : table_m[addr][7:0]};
         end
         FN_READ_HOLD, FN_READ_INPUT: begin
            qty = {b[4], b[5]};
            if (qty == 0 || qty > MAX_RD || addr + qty > NREGS) return;
            tx = {id_m, code[7:0], 8'(2 * qty)};
            for (int i = 0; i < qty; i++) begin
               tx.push_back(table_m[addr+i][15:8]);
               tx.push_back(table_m[addr+i][7:0]);
            end
         end
         FN_WRITE_COIL, FN_WRITE_REG: begin
            table_m[addr] = {b[4], b[5]};
            wev = 1; wreg = addr[5:0];
            for (int i = 0; i < 8; i++) tx.push_back(b[i]);
            return;
         end
         default: begin
            if (addr + 1 >= NREGS) return;
            table_m[addr] = {b[9], b[10]};
            table_m[addr+1] = {b[7], b[8]};
            wev = 1; wreg = addr[5:0];
            tx = {id_m, code[7:0], 8'd0, addr[7:0], 8'd0, 8'd2};
         end
      endcase
      b = new[tx.size()];
      foreach (tx[i]) b[i] = tx[i];
      c = crc_of(b, tx.size());
      tx.push_back(c[7:0]);
      tx.push_back(c[15:8]);
   endfunction

   function automatic void predict_slave(input req_item_t it);
      logic [7:0] tx [$];
      bit wev, rdv, closing;
      logic [5:0] wreg;
      logic [15:0] rdval;
      slave_out_t o;
      wev = 0; rdv = 0; wreg = 0; rdval = 0; closing = 0;
      case (it.kind)
         REQ_BYTE: begin
            if (!inframe_m) begin
               if (it.rx_byte == id_m) begin
                  rxbuf_m[0] = it.rx_byte; rxcnt_m = 1; inframe_m = 1; gap_m = 0;
               end
            end else if (rxcnt_m < BUF_BYTES) begin
               rxbuf_m[rxcnt_m] = it.rx_byte; rxcnt_m++; gap_m = 0;
            end
            closing = inframe_m && rxcnt_m >= BUF_BYTES;
         end
         REQ_TICK: begin
            if (link_m < 16'hFFFF) link_m++;
            if (inframe_m) begin
               if (gap_m < 1023) gap_m++;
               closing = gap_m >= gapcfg_m;
            end
         end
         REQ_HOST_WR: table_m[it.host_reg] = it.host_value;
         default: begin
            rdv = 1; rdval = table_m[it.host_reg];
         end
      endcase
      if (closing) begin
         answer_frame(tx, wev, wreg);
         inframe_m = 0; rxcnt_m = 0; gap_m = 0;
         if (tx.size() > 0) link_m = 0;
      end
      o = '0;
      o.read_valid = rdv; o.read_value = rdval;
      o.write_event = wev; o.written_reg = wreg;
      o.link_up = link_m < tmo_m;
      if (tx.size() == 0) reply_q.push_back(o);
      foreach (tx[k]) begin
         o.tx_valid = 1; o.tx_byte = tx[k]; o.tx_last = (k == tx.size() - 1);
         reply_q.push_back(o);
      end
   endfunction

   // driver
   int req_wait;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0; req_wait <= 0;
      end else if (req_tvalid && !req_tready) begin
      end else if (req_tvalid && req_tready) begin
         predict_slave(pending_q.pop_front());
         req_tvalid <= 0;
         req_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end else if (req_wait > 0) begin
         req_wait <= req_wait - 1;
      end else if (pending_q.size() > 0) begin
         req_tvalid <= 1;
         req_tuser <= pending_q[0].kind;
         req_tdata <= {2'b00, pending_q[0].host_value, pending_q[0].host_reg,
                       pending_q[0].rx_byte};
      end
   end

   // monitor
   int rsp_wait, hold_cnt;
   always @(posedge clock) begin
      slave_out_t got, want;
      if (reset) begin
         rsp_tready <= 0; rsp_wait <= 0; hold_cnt <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[8:1], rsp_tlast, rsp_tdata[9], rsp_tdata[25:10],
                   rsp_tdata[26], rsp_tdata[32:27], rsp_tdata[33]};
            if (reply_q.size() == 0) begin
               report("unexpected transaction", got[31:0], 0);
            end else begin
               want = reply_q.pop_front();
               if (got.tx_valid != want.tx_valid) report("tx_valid", got.tx_valid, want.tx_valid);
               if (got.tx_byte != want.tx_byte) report("tx_byte", got.tx_byte, want.tx_byte);
               if (got.tx_last != want.tx_last) report("tx_last", got.tx_last, want.tx_last);
               if (got.read_valid != want.read_valid)
                  report("read_valid", got.read_valid, want.read_valid);
               if (got.read_value != want.read_value)
                  report("read_value", got.read_value, want.read_value);
               if (got.write_event != want.write_event)
                  report("write_event", got.write_event, want.write_event);
               if (got.written_reg != want.written_reg)
                  report("written_reg", got.written_reg, want.written_reg);
               if (got.link_up != want.link_up) report("link_up", got.link_up, want.link_up);
            end
         end
         if (hold_rsp && hold_cnt < 300) begin
            hold_cnt <= hold_cnt + 1; rsp_tready <= 0;
         end else if (rsp_tvalid && rsp_tready || rsp_wait == 0 && !rsp_tready) begin
            if (rsp_wait == 0 && !(rsp_tvalid && rsp_tready)) rsp_tready <= 1;
            else begin
               rsp_wait <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
               rsp_tready <= 0;
               if (!hold_rsp) hold_cnt <= 0;
            end
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
         end
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= 4 * idx; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         CSR_SLAVE_ID:     id_m = val[7:0];
         CSR_FRAME_GAP:    gapcfg_m = val[9:0];
         CSR_LINK_TIMEOUT: tmo_m = val[15:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      wait (pending_q.size() == 0 && !req_tvalid);
      wait (reply_q.size() == 0);
      repeat (80) @(posedge clock);
   endtask

   function automatic void add(input req_kind_type k, input logic [7:0] b,
                               input logic [5:0] r = 0, input logic [15:0] v = 0);
      req_item_t it;
      it.kind = k; it.rx_byte = b; it.host_reg = r; it.host_value = v;
      pending_q.push_back(it);
   endfunction

   // queue a frame with its crc (corrupted when good_crc is clear), then enough ticks to close it
   function automatic void add_frame(input logic [7:0] body [$], input bit good_crc);
      logic [7:0] b [];
      logic [15:0] c;
      b = new[body.size()];
      foreach (body[i]) b[i] = body[i];
      c = crc_of(b, body.size());
      if (!good_crc) c ^= 16'h0100 << $urandom_range(0, 7);
      foreach (body[i]) add(REQ_BYTE, body[i]);
      if (body.size() + 2 <= BUF_BYTES) add(REQ_BYTE, c[7:0]);
      if (body.size() + 2 <= BUF_BYTES) add(REQ_BYTE, c[15:8]);
      for (int i = 0; i <= gapcfg_m; i++) add(REQ_TICK, 0);
   endfunction

   function automatic void add_random_frame();
      logic [7:0] body [$];
      logic [7:0] codes [7];
      logic [7:0] code;
      int sel;
      codes = '{FN_READ_HI, FN_READ_LO, FN_READ_HOLD, FN_READ_INPUT,
                FN_WRITE_COIL, FN_WRITE_REG, FN_WRITE_MULTI};
      sel = $urandom_range(0, 9);
      code = sel < 7 ? codes[sel] : 8'($urandom);
      body = {id_m, code, 8'($urandom_range(0, 7) == 0 ? $urandom : 0),
              8'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, NREGS - 1)),
              8'($urandom_range(0, 7) == 0 ? $urandom : 0),
              8'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, MAX_RD)),
              8'($urandom)};
      if (code == FN_WRITE_MULTI || $urandom_range(0, 5) == 0)
         repeat ($urandom_range(0, 7)) body.push_back(8'($urandom));
      if (code == FN_WRITE_COIL || code == FN_WRITE_REG) void'(body.pop_back());
      add_frame(body, $urandom_range(0, 7) != 0);
   endfunction

   task automatic random_phase(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 9);
         if (k < 5) add_random_frame();
         else if (k == 5) add(REQ_BYTE, 8'($urandom));
         else if (k == 6) add(REQ_TICK, 0);
         else if (k == 7) add(REQ_HOST_WR, 0, 6'($urandom), 16'($urandom));
         else add(REQ_HOST_RD, 0, 6'($urandom));
      end
   endtask

   initial begin
      logic [7:0] full [$];
      errors = 0; hold_rsp = 0;
      for (int i = 0; i < NREGS; i++) table_m[i] = 0;
      rxcnt_m = 0; gap_m = 0; inframe_m = 0;
      id_m = SLAVE_ID_RESET; gapcfg_m = FRAME_GAP_RESET; tmo_m = LINK_TIMEOUT_RESET;
      link_m = tmo_m;
      reset = 1; req_tvalid = 0; req_tdata = 0; req_tuser = 0; rsp_tready = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      add(REQ_HOST_WR, 0, 6'd0, 16'hFFFF);
      add(REQ_HOST_WR, 0, 6'd63, 16'hA5C3);
      add(REQ_HOST_RD, 0, 6'd63);
      add(REQ_HOST_RD, 0, 6'd5);
      add(REQ_BYTE, 8'hFF);
      add_frame({8'd1, FN_READ_HI, 8'd0, 8'd0, 8'd0, 8'd1}, 1);
      add_frame({8'd1, FN_READ_LO, 8'd0, 8'd63, 8'd0, 8'd1}, 1);
      add_frame({8'd1, FN_READ_HOLD, 8'd0, 8'd56, 8'd0, 8'd8}, 1);
      add_frame({8'd1, FN_READ_INPUT, 8'd0, 8'd60, 8'd0, 8'd8}, 1);
      add_frame({8'd1, FN_WRITE_REG, 8'd0, 8'd7, 8'h12, 8'h34}, 1);
      add_frame({8'd1, FN_WRITE_COIL, 8'd0, 8'd64, 8'hFF, 8'h00}, 1);
      add_frame({8'd1, FN_WRITE_MULTI, 8'd0, 8'd62, 8'd0, 8'd2, 8'd4,
                 8'hAB, 8'hCD, 8'hEF, 8'h01}, 1);
      add_frame({8'd1, FN_WRITE_MULTI, 8'd0, 8'd63, 8'd0, 8'd2, 8'd4,
                 8'h1, 8'h2, 8'h3, 8'h4}, 1);
      add_frame({8'd1, FN_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd0}, 1);
      add_frame({8'd1, FN_READ_HI, 8'd0, 8'd1}, 1);
      add_frame({8'd1, FN_WRITE_REG, 8'd0, 8'd1, 8'd0, 8'd1}, 0);
      add_frame({8'd1, 8'd7, 8'd0, 8'd1, 8'd0, 8'd1}, 1);
      full = {};
      repeat (BUF_BYTES) full.push_back(8'($urandom));
      full[0] = 8'd1;
      foreach (full[i]) add(REQ_BYTE, full[i]);
      add(REQ_HOST_RD, 0, 6'd62);
      drain();

      csr_write(CSR_SLAVE_ID, 247);
      csr_write(CSR_FRAME_GAP, 1);
      csr_write(CSR_LINK_TIMEOUT, 1);
      random_phase(20);
      drain();

      csr_write(CSR_SLAVE_ID, $urandom_range(1, 247));
      csr_write(CSR_FRAME_GAP, $urandom_range(1, 5));
      csr_write(CSR_LINK_TIMEOUT, 65535);
      fork
         random_phase(25);
         begin
            hold_rsp = 1;
            wait (hold_cnt >= 300);
            hold_rsp = 0;
         end
      join
      drain();

      csr_write(CSR_SLAVE_ID, 1);
      csr_write(CSR_FRAME_GAP, 1000);
      csr_write(CSR_LINK_TIMEOUT, 20);
      add_frame({8'd1, FN_READ_HI, 8'd0, 8'd3, 8'd0, 8'd1}, 1);
      for (int i = 0; i < 1000; i++) pending_q.push_back('{REQ_TICK, 8'($urandom), 6'($urandom), 16'($urandom)});
      drain();

      csr_write(CSR_FRAME_GAP, 2);
      random_phase(30);
      drain();

      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
